// ===== rtl/core/fupp_pkg.sv =====
// Shared types, character codes and hex helpers for the form body pair parser.
`timescale 1ns / 1ps

package fupp_pkg;

	// Most results that one request can cause.
	localparam int MAX_RES = 3;
	// Default depth of the result queue.
	localparam int RES_FIFO_DEPTH = 8;

	// Result kinds.
	localparam logic [1:0] OK_KEY   = 2'd0;
	localparam logic [1:0] OK_VALUE = 2'd1;
	localparam logic [1:0] OK_MARK  = 2'd2;

	// Request kinds.
	localparam logic IK_BYTE = 1'b0;
	localparam logic IK_END  = 1'b1;

	// Characters with a meaning in a form body.
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_EQUALS  = 8'h3D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_0       = 8'h30;
	localparam logic [7:0] CH_9       = 8'h39;
	localparam logic [7:0] CH_UA      = 8'h41;
	localparam logic [7:0] CH_UF      = 8'h46;
	localparam logic [7:0] CH_LA      = 8'h61;
	localparam logic [7:0] CH_LF      = 8'h66;

	typedef enum logic [1:0] {
		PH_START,
		PH_KEY,
		PH_VALUE
	} parse_phase_t;

	typedef enum logic [1:0] {
		ESC_NONE,
		ESC_PCT,
		ESC_DIG
	} esc_phase_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] in_byte;
	} item_t;

	typedef struct packed {
		logic [1:0] out_kind;
		logic [7:0] out_byte;
		logic       last;
	} result_t;

	typedef struct packed {
		parse_phase_t phase;
		esc_phase_t   esc;
		logic [7:0]   held;
		logic         key_seen;
	} parse_state_t;

	// Everything that one request produces, handed to the result queue.
	typedef struct packed {
		logic [1:0]                 count;
		result_t [MAX_RES-1:0]      res;
	} burst_t;

	function automatic logic is_hex(input logic [7:0] c);
		return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_UA) && (c <= CH_UF)) ||
			((c >= CH_LA) && (c <= CH_LF));
	endfunction

	// Value of a hex digit; letters have 1 to 6 in their low nibble.
	function automatic logic [3:0] hex_nib(input logic [7:0] c);
		logic [3:0] v;
		if ((c >= CH_0) && (c <= CH_9)) begin
			v = c[3:0];
		end else if (is_hex(c)) begin
			v = c[3:0] + 4'd9;
		end else begin
			v = 4'd0;
		end
		return v;
	endfunction

endpackage

// ===== rtl/core/form_urlencoded_pair_parser.sv =====
// Top level of the form body pair parser: input register, decode and result queue.
// A request is captured in the input register, decoded from there and written into the
// result queue, whose head drives the result port. Throughput: one request a cycle
// while the result queue has room for three results; results leave at one a cycle while
// result_stall is low, so a request with several results holds later ones back.
// Reset: arst_n clears the parser state, the input valid flag and the queue pointers.
`timescale 1ns / 1ps

module form_urlencoded_pair_parser
	import fupp_pkg::*;
#(
	parameter int FifoDepth = RES_FIFO_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	// Input register: one request waits here until the queue can take its results.
	item_t        item_s1;
	logic         valid_s1;
	// Parser state as it stands after the last decoded request.
	parse_state_t state_q;
	parse_state_t state_nxt;
	burst_t       burst;
	logic         room;
	logic         advance;
	logic         accept;
	logic         pop;

	// A request is decoded once the queue has room for the most results it may
	// cause. The stall looks only at the held request and the queue fill, never
	// at the incoming valid, so a new request can land in every cycle while there is room.
	// After reset the parser starts at the beginning of a key with no escape pending.
	assign advance    = valid_s1 && room;
	assign item_stall = valid_s1 && !room;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk) begin
		if (accept) item_s1 <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= '{phase: PH_START, esc: ESC_NONE, held: 8'd0, key_seen: 1'b0};
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) state_q <= state_nxt;
		end
	end

	// All the parsing rules live in one short block of logic: escapes, plus signs, the
	// key and value split, the separator handling and the end-of-body marker.
	fupp_step u_step (
		.item  (item_s1),
		.cur   (state_q),
		.nxt   (state_nxt),
		.burst (burst)
	);

	// The queue also serves as the output register: its head is stable while
	// the consumer stalls, and the parser keeps taking requests while the queue has room.
	assign pop = result_valid && !result_stall;

	fupp_result_fifo #(
		.Depth (FifoDepth)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.burst     (burst),
		.push      (advance),
		.pop       (pop),
		.room      (room),
		.not_empty (result_valid),
		.head      (result)
	);

endmodule

// ===== rtl/core/fupp_step.sv =====
// Per-byte decode: next parser state and up to three results for one request.
`timescale 1ns / 1ps

module fupp_step
	import fupp_pkg::*;
(
	input  item_t        item,
	input  parse_state_t cur,
	output parse_state_t nxt,
	output burst_t       burst
);

	parse_phase_t ph;
	esc_phase_t   esc;
	logic [7:0]   held;
	logic         ks;
	logic [1:0]   n;
	result_t [MAX_RES-1:0] res;
	logic         do_plain;
	logic         sep;
	logic [7:0]   b;
	logic [1:0]   dkind;

	always_comb begin
		ph       = cur.phase;
		esc      = cur.esc;
		held     = cur.held;
		ks       = cur.key_seen;
		n        = 2'd0;
		res      = '0;
		do_plain = 1'b0;
		b        = item.in_byte;
		sep      = (b == CH_AMP) || (b == CH_SEMI);
		dkind    = OK_KEY;

		if (item.kind == IK_END) begin
			if (ks) begin
				res[n] = '{out_kind: OK_MARK, out_byte: 8'd0, last: 1'b0};
				n = n + 2'd1;
			end
			ph   = PH_START;
			esc  = ESC_NONE;
			held = 8'd0;
			ks   = 1'b0;
		end else begin
			case (esc)
				ESC_PCT: begin
					if (is_hex(b)) begin
						held = b;
						esc  = ESC_DIG;
					end else begin
						esc = ESC_NONE;
						dkind = (ph == PH_VALUE) ? OK_VALUE : OK_KEY;
						if (ph != PH_VALUE) ks = 1'b1;
						res[n] = '{out_kind: dkind, out_byte: CH_PERCENT, last: 1'b0};
						n = n + 2'd1;
						do_plain = 1'b1;
					end
				end
				ESC_DIG: begin
					esc = ESC_NONE;
					dkind = (ph == PH_VALUE) ? OK_VALUE : OK_KEY;
					if (ph != PH_VALUE) ks = 1'b1;
					if (is_hex(b)) begin
						res[n] = '{out_kind: dkind, out_byte: {hex_nib(held), hex_nib(b)},
							last: 1'b0};
						n = n + 2'd1;
					end else begin
						res[n] = '{out_kind: dkind, out_byte: CH_PERCENT, last: 1'b0};
						n = n + 2'd1;
						res[n] = '{out_kind: dkind, out_byte: held, last: 1'b0};
						n = n + 2'd1;
						do_plain = 1'b1;
					end
					held = 8'd0;
				end
				default: begin
					esc = ESC_NONE;
					do_plain = 1'b1;
				end
			endcase

			if (do_plain) begin
				if ((ph != PH_KEY) && (ph != PH_VALUE) && sep) begin
					// Separators at the start of a key are dropped.
				end else begin
					if ((ph != PH_KEY) && (ph != PH_VALUE)) ph = PH_KEY;
					if (sep) begin
						res[n] = '{out_kind: OK_MARK, out_byte: 8'd0, last: 1'b0};
						n = n + 2'd1;
						ph = PH_START;
						ks = 1'b0;
					end else if ((b == CH_EQUALS) && (ph == PH_KEY)) begin
						ph = PH_VALUE;
					end else if (b == CH_PERCENT) begin
						esc = ESC_PCT;
					end else begin
						dkind = (ph == PH_VALUE) ? OK_VALUE : OK_KEY;
						if (ph != PH_VALUE) ks = 1'b1;
						res[n] = '{out_kind: dkind,
							out_byte: (b == CH_PLUS) ? CH_SPACE : b, last: 1'b0};
						n = n + 2'd1;
					end
				end
			end
		end

		if (n != 2'd0) res[n - 2'd1].last = 1'b1;

		nxt   = '{phase: ph, esc: esc, held: held, key_seen: ks};
		burst = '{count: n, res: res};
	end

endmodule

// ===== rtl/core/fupp_result_fifo.sv =====
// Result queue: takes up to three results a cycle, gives out one a cycle.
`timescale 1ns / 1ps

module fupp_result_fifo
	import fupp_pkg::*;
#(
	parameter int Depth = RES_FIFO_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  burst_t  burst,
	input  logic    push,
	input  logic    pop,
	output logic    room,
	output logic    not_empty,
	output result_t head
);

	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	result_t          mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic [PtrW-1:0]  wr_idx [MAX_RES+1];
	logic [PtrW:0]    sum;
	logic [1:0]       n_push;

	always_comb begin
		for (int i = 0; i <= MAX_RES; i++) begin
			sum = {1'b0, wr_ptr_q} + (PtrW + 1)'(i);
			if (sum >= (PtrW + 1)'(Depth)) sum = sum - (PtrW + 1)'(Depth);
			wr_idx[i] = sum[PtrW-1:0];
		end
	end

	assign n_push    = push ? burst.count : 2'd0;
	assign not_empty = (count_q != '0);
	assign room      = (count_q <= CntW'(Depth - MAX_RES));
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (2'(i) < n_push) mem_q[wr_idx[i]] <= burst.res[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_idx[n_push];
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			count_q <= count_q + CntW'(n_push) - CntW'(pop);
		end
	end

endmodule

// ===== rtl/core/fupp_checker.sv =====
// Port-level checks for the form body pair parser, bound to the top level.
`timescale 1ns / 1ps

module fupp_checker
	import fupp_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.out_kind == OK_KEY) || (result.out_kind == OK_VALUE) ||
			(result.out_kind == OK_MARK))
		else $error("result kind out of range");

	a_mark_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.out_kind == OK_MARK) |-> result.out_byte == 8'd0)
		else $error("pair marker carries a non-zero byte");

	a_mark_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.out_kind == OK_MARK) |-> result.last)
		else $error("pair marker is not the last result of its request");

endmodule

bind form_urlencoded_pair_parser fupp_checker u_fupp_checker (.*);
